@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RTH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RTH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rth_pkg.sv @@
// Types and constants for the RGB to HSL converter.
`timescale 1ns / 1ps

package rth_pkg;

  localparam int CH_W  = 8;
  localparam int NUM_W = 11;
  localparam int DEN_W = 12;

  localparam logic [NUM_W-1:0] LIGHT_DEN = 11'd510;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } rth_sel_t;

endpackage

@@ rtl/rth_if.sv @@
// Valid/ready channel interfaces for pixel and HSL result requests.
`timescale 1ns / 1ps

interface rth_in_if
  import rth_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_out_if #(
  parameter int FRAC_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS-1:0] hue;
  logic [FRAC_BITS-1:0] saturation;
  logic [FRAC_BITS-1:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input lightness,
                output ready);
endinterface

@@ rtl/rth_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module rth_div #(
  parameter int Q_W   = 16,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] num_hi,
  input  logic [Q_W-1:0]   num_lo,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  // num_hi must be below den so the quotient fits in Q_W bits
  logic [DEN_W-1:0] rem_r [0:Q_W];
  logic [Q_W-1:0]   lq_r  [0:Q_W];
  logic [DEN_W-1:0] den_r [0:Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_hi;
      lq_r[0]  <= num_lo;
      den_r[0] <= den;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W:0]   t;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;
    logic [Q_W-1:0]   lq_nxt;

    always_comb begin
      t       = {rem_r[k], lq_r[k][Q_W-1]};
      diff    = t - {1'b0, den_r[k]};
      ge      = (t >= {1'b0, den_r[k]});
      rem_nxt = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
      lq_nxt  = {lq_r[k][Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt;
        lq_r[k+1]  <= lq_nxt;
        den_r[k+1] <= den_r[k];
      end
    end
  end

  assign quo = lq_r[Q_W];

endmodule

@@ rtl/rgb_to_hsl_converter.sv @@
// Top level of the RGB to HSL converter.
// Takes one 8-bit RGB pixel per clock while in_chan.ready is high and returns hue,
// saturation and lightness as FRAC_BITS-bit fractions (all ones = 1.0, hue a fraction
// of a full turn), each rounded to nearest with ties up. Gray pixels give zero hue
// and saturation. Throughput is one pixel per cycle while in_chan.ready is high; a
// pixel passes through four front stages, the one-bit-per-stage divider pipelines and
// the output register. A two-entry output buffer keeps in_chan.ready high while one
// result waits; the pipeline stalls as a whole only when both entries are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_to_hsl_converter
  import rth_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  rth_in_if.sink    in_chan,
  rth_out_if.source out_chan
);

  localparam int Q_W    = FRAC_BITS;
  localparam int NW     = FRAC_BITS + DEN_W;
  localparam int LP_W   = FRAC_BITS + 1;
  localparam int LV_W   = 16;
  localparam int CH_MAX = (2 ** CH_W) - 1;
  // 2^FRAC_BITS = CH_MAX * LQ + LR
  localparam int LQ     = (2 ** FRAC_BITS) / CH_MAX;
  localparam int LR     = (2 ** FRAC_BITS) % CH_MAX;

  function automatic logic [NW-1:0] build_n(input logic [NUM_W-1:0] num,
                                           input logic [NUM_W-1:0] den);
    logic [NW-1:0] n;
    begin
      n = NW'(num);
      return (n << (FRAC_BITS + 1)) - (n << 1) + NW'(den);
    end
  endfunction

  logic en;

  // stage 1: input register
  logic            v1_r;
  logic [CH_W-1:0] r1_r, g1_r, b1_r;

  // stage 2: max, min, sector
  logic            v2_r;
  logic [CH_W-1:0] r2_r, g2_r, b2_r, mx2_r, mn2_r;
  rth_sel_t        sel2_r;
  logic [CH_W-1:0] mx2_nxt, mn2_nxt;
  rth_sel_t        sel2_nxt;

  // stage 3: range, sum, hue operands
  logic            v3_r;
  logic [CH_W-1:0] d3_r, hx3_r, hy3_r;
  logic [CH_W:0]   sum3_r;
  rth_sel_t        sel3_r;
  logic            neg3_r;
  logic [CH_W-1:0] hx3_nxt, hy3_nxt;

  // stage 4: numerators and denominators
  logic             v4_r, gray4_r;
  logic [NUM_W-1:0] hnum4_r, hden4_r;
  logic [CH_W-1:0]  snum4_r, sden4_r;
  logic [Q_W-1:0]   lh4_r;
  logic [LV_W-1:0]  lv4_r, lv4_nxt;
  logic [LP_W-1:0]  lprod_nxt;
  logic [NUM_W-1:0] d6_nxt, base_nxt, hnum4_nxt;
  logic [CH_W-1:0]  sden4_nxt;

  // divider inputs
  logic [NW-1:0] hn, sn;

  // lightness finish: floor(x / 255) for x below 65535
  logic [LV_W-1:0] lx, lt;
  logic [Q_W-1:0]  lit_nxt;

  // divider side band
  logic           dv_r [0:Q_W];
  logic           dg_r [0:Q_W];
  logic [Q_W-1:0] dl_r [0:Q_W];
  logic [Q_W-1:0] hue_q, sat_q, lit_q;

  // output register and skid entry
  logic           out_v_r, skid_v_r;
  logic           out_v_nxt, skid_v_nxt;
  logic [Q_W-1:0] out_h_r, out_s_r, out_l_r;
  logic [Q_W-1:0] skid_h_r, skid_s_r, skid_l_r;
  logic [Q_W-1:0] fin_h, fin_s;
  logic           push, take;

  assign en = !skid_v_r;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r <= in_chan.red;
      g1_r <= in_chan.green;
      b1_r <= in_chan.blue;
    end
  end

  always_comb begin
    if (r1_r >= g1_r && r1_r >= b1_r) begin
      sel2_nxt = SEL_RED;
      mx2_nxt  = r1_r;
    end else if (g1_r >= b1_r) begin
      sel2_nxt = SEL_GREEN;
      mx2_nxt  = g1_r;
    end else begin
      sel2_nxt = SEL_BLUE;
      mx2_nxt  = b1_r;
    end
    mn2_nxt = r1_r;
    if (g1_r < mn2_nxt) mn2_nxt = g1_r;
    if (b1_r < mn2_nxt) mn2_nxt = b1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r   <= r1_r;
      g2_r   <= g1_r;
      b2_r   <= b1_r;
      mx2_r  <= mx2_nxt;
      mn2_r  <= mn2_nxt;
      sel2_r <= sel2_nxt;
    end
  end

  always_comb begin
    unique case (sel2_r)
      SEL_RED: begin
        hx3_nxt = g2_r;
        hy3_nxt = b2_r;
      end
      SEL_GREEN: begin
        hx3_nxt = b2_r;
        hy3_nxt = r2_r;
      end
      SEL_BLUE: begin
        hx3_nxt = r2_r;
        hy3_nxt = g2_r;
      end
      default: begin
        hx3_nxt = '0;
        hy3_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r   <= mx2_r - mn2_r;
      sum3_r <= {1'b0, mx2_r} + {1'b0, mn2_r};
      sel3_r <= sel2_r;
      hx3_r  <= hx3_nxt;
      hy3_r  <= hy3_nxt;
      neg3_r <= (hx3_nxt < hy3_nxt);
    end
  end

  always_comb begin
    d6_nxt = (NUM_W'(d3_r) << 2) + (NUM_W'(d3_r) << 1);
    unique case (sel3_r)
      SEL_RED:   base_nxt = neg3_r ? d6_nxt : '0;
      SEL_GREEN: base_nxt = NUM_W'(d3_r) << 1;
      SEL_BLUE:  base_nxt = NUM_W'(d3_r) << 2;
      default:   base_nxt = '0;
    endcase
    hnum4_nxt = base_nxt + NUM_W'(hx3_r) - NUM_W'(hy3_r);
    // lighter half uses 510 - sum; the result never exceeds 255
    if (sum3_r[CH_W]) sden4_nxt = CH_W'(LIGHT_DEN - NUM_W'(sum3_r));
    else              sden4_nxt = sum3_r[CH_W-1:0];
    // FULL * sum + 255 = 510 * (LQ * sum / 2) + (LR - 1) * sum + 255, split on parity
    lprod_nxt = LP_W'(LQ) * LP_W'(sum3_r);
    lv4_nxt   = LV_W'(LR - 1) * LV_W'(sum3_r) + LV_W'(CH_MAX)
              + (lprod_nxt[0] ? LV_W'(CH_MAX) : '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hnum4_r <= hnum4_nxt;
      hden4_r <= d6_nxt;
      snum4_r <= d3_r;
      sden4_r <= sden4_nxt;
      lh4_r   <= lprod_nxt[LP_W-1:1];
      lv4_r   <= lv4_nxt;
      gray4_r <= (d3_r == '0);
    end
  end

  assign hn = build_n(hnum4_r, hden4_r);
  assign sn = build_n(NUM_W'(snum4_r), NUM_W'(sden4_r));

  assign lx      = LV_W'(lv4_r[LV_W-1:1]);
  assign lt      = lx + LV_W'(1) + (lx >> CH_W);
  assign lit_nxt = lh4_r + Q_W'(lt[LV_W-1:CH_W]);

  rth_div #(.Q_W(Q_W), .DEN_W(DEN_W)) u_div_hue (
    .clk    (clk),
    .en     (en),
    .num_hi (hn[NW-1:Q_W]),
    .num_lo (hn[Q_W-1:0]),
    .den    ({hden4_r, 1'b0}),
    .quo    (hue_q)
  );

  rth_div #(.Q_W(Q_W), .DEN_W(DEN_W)) u_div_sat (
    .clk    (clk),
    .en     (en),
    .num_hi (sn[NW-1:Q_W]),
    .num_lo (sn[Q_W-1:0]),
    .den    ({3'b000, sden4_r, 1'b0}),
    .quo    (sat_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dg_r[0] <= gray4_r;
      dl_r[0] <= lit_nxt;
      for (int k = 0; k < Q_W; k++) begin
        dg_r[k+1] <= dg_r[k];
        dl_r[k+1] <= dl_r[k];
      end
    end
  end

  assign lit_q = dl_r[Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      for (int k = 0; k <= Q_W; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      v1_r    <= in_chan.valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      dv_r[0] <= v4_r;
      for (int k = 0; k < Q_W; k++) dv_r[k+1] <= dv_r[k];
    end
  end

  assign fin_h = dg_r[Q_W] ? '0 : hue_q;
  assign fin_s = dg_r[Q_W] ? '0 : sat_q;
  assign push  = en && dv_r[Q_W];
  assign take  = out_v_r && out_chan.ready;

  always_comb begin
    if (!out_v_r || take) begin
      out_v_nxt  = skid_v_r || push;
      skid_v_nxt = 1'b0;
    end else begin
      out_v_nxt  = out_v_r;
      skid_v_nxt = push ? 1'b1 : skid_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || take) begin
      if (skid_v_r) begin
        out_h_r <= skid_h_r;
        out_s_r <= skid_s_r;
        out_l_r <= skid_l_r;
      end else begin
        out_h_r <= fin_h;
        out_s_r <= fin_s;
        out_l_r <= lit_q;
      end
    end else if (push) begin
      skid_h_r <= fin_h;
      skid_s_r <= fin_s;
      skid_l_r <= lit_q;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.hue        = out_h_r;
  assign out_chan.saturation = out_s_r;
  assign out_chan.lightness  = out_l_r;

  `RTH_ASSERT_IMP(a_skid_needs_out, skid_v_r, out_v_r, "skid full with output empty")
  `RTH_ASSERT_NXT(a_push_lands, push, out_v_r, "result left pipeline but output is empty")
  `RTH_ASSERT_NXT(a_stall_keeps_skid, skid_v_r && !out_chan.ready, skid_v_r && out_v_r,
                  "stalled request dropped from skid")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the RGB to HSL converter: directed table, then random pixels.
`timescale 1ns / 1ps

module tb
  import rth_pkg::*;
();

  localparam int FRAC = 16;
  localparam longint unsigned FULL = (64'd1 << FRAC) - 1;
  localparam int LATENCY = FRAC + 5;
  localparam int STUCK_LIMIT = 2000;
  localparam int RANDOM_PIXELS = 1600;
  localparam int DIR_N = 24;

  typedef struct packed {
    logic [FRAC-1:0] hue;
    logic [FRAC-1:0] saturation;
    logic [FRAC-1:0] lightness;
  } hsl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            known;
    logic [FRAC-1:0] hue;
    logic [FRAC-1:0] sat;
    logic [FRAC-1:0] lit;
  } pixel_row_t;

  // known = 1: expected HSL typed in; known = 0: taken from the predictor
  localparam pixel_row_t DIRECTED [DIR_N] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, 16'd0,     16'd0,     16'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 16'd0,     16'd0,     16'd65535},
    '{8'd255, 8'd0,   8'd0,   1'b1, 16'd0,     16'd65535, 16'd32768},
    '{8'd0,   8'd255, 8'd0,   1'b1, 16'd21845, 16'd65535, 16'd32768},
    '{8'd0,   8'd0,   8'd255, 1'b1, 16'd43690, 16'd65535, 16'd32768},
    '{8'd255, 8'd255, 8'd0,   1'b1, 16'd10923, 16'd65535, 16'd32768},
    '{8'd0,   8'd255, 8'd255, 1'b1, 16'd32768, 16'd65535, 16'd32768},
    '{8'd255, 8'd0,   8'd255, 1'b1, 16'd54613, 16'd65535, 16'd32768},
    '{8'd128, 8'd128, 8'd128, 1'b1, 16'd0,     16'd0,     16'd32896},
    '{8'd1,   8'd1,   8'd1,   1'b1, 16'd0,     16'd0,     16'd257},
    '{8'd254, 8'd254, 8'd254, 1'b1, 16'd0,     16'd0,     16'd65278},
    '{8'd255, 8'd0,   8'd1,   1'b0, 16'd0,     16'd0,     16'd0},
    '{8'd1,   8'd0,   8'd0,   1'b0, 16'd0,     16'd0,     16'd0},
    '{8'd255, 8'd254, 8'd255, 1'b0, 16'd0,     16'd0,     16'd0},
    '{8'd0,   8'd1,   8'd1,   1'b0, 16'd0,     16'd0,     16'd0},
    '{8'd254, 8'd255, 8'd255, 1'b0, 16'd0,     16'd0,     16'd0},
    '{8'd200, 8'd100, 8'd50,  1'b0, 16'd0,     16'd0,     16'd0},
    '{8'd50,  8'd200, 8'd100, 1'b0, 16'd0,     16'd0,     16'd0},
    '{8'd100, 8'd50,  8'd200, 1'b0, 16'd0,     16'd0,     16'd0},
    '{8'd128, 8'd127, 8'd128, 1'b0, 16'd0,     16'd0,     16'd0},
    '{8'd200, 8'd55,  8'd100, 1'b0, 16'd0,     16'd0,     16'd0},
    '{8'd201, 8'd55,  8'd100, 1'b0, 16'd0,     16'd0,     16'd0},
    '{8'd255, 8'd128, 8'd0,   1'b0, 16'd0,     16'd0,     16'd0},
    '{8'd170, 8'd170, 8'd85,  1'b0, 16'd0,     16'd0,     16'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  rth_in_if in_chan ();
  rth_out_if #(.FRAC_BITS(FRAC)) out_chan ();

  rgb_to_hsl_converter #(.FRAC_BITS(FRAC)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  hsl_t hsl_pending [$];
  int   mismatches = 0;
  bit   no_gaps = 1'b0;
  int   stuck_cycles = 0;

  // rounded FULL * num / den, ties up
  function automatic longint unsigned round_frac(longint unsigned num, longint unsigned den);
    return (2 * FULL * num + den) / (2 * den);
  endfunction

  function automatic hsl_t predict_hsl(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                       logic [CH_W-1:0] b);
    longint unsigned rr, gg, bb, mx, mn, d, sum, hnum, sden;
    hsl_t res;
    rr = 64'(r);
    gg = 64'(g);
    bb = 64'(b);
    mx = rr;
    if (gg > mx) mx = gg;
    if (bb > mx) mx = bb;
    mn = rr;
    if (gg < mn) mn = gg;
    if (bb < mn) mn = bb;
    d = mx - mn;
    sum = mx + mn;
    res.hue = '0;
    res.saturation = '0;
    res.lightness = FRAC'(round_frac(sum, 510));
    if (d != 0) begin
      sden = (sum > 255) ? (510 - sum) : sum;
      res.saturation = FRAC'(round_frac(d, sden));
      if (mx == rr) hnum = (gg >= bb) ? (gg - bb) : (6 * d - (bb - gg));
      else if (mx == gg) hnum = 2 * d + bb - rr;
      else hnum = 4 * d + rr - gg;
      res.hue = FRAC'(round_frac(hnum, 6 * d));
    end
    return res;
  endfunction

  function automatic int idle_cycles();
    return no_gaps ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                            hsl_t want);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.red   <= r;
    in_chan.green <= g;
    in_chan.blue  <= b;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    hsl_pending.push_back(want);
  endtask

  initial begin
    pixel_row_t      row;
    logic [CH_W-1:0] r, g, b, v, w;
    in_chan.valid = 1'b0;
    in_chan.red = '0;
    in_chan.green = '0;
    in_chan.blue = '0;
    out_chan.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      row = DIRECTED[i];
      send_pixel(row.red, row.green, row.blue,
                 row.known ? hsl_t'{row.hue, row.sat, row.lit}
                           : predict_hsl(row.red, row.green, row.blue));
    end

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n % 200 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_PIXELS / 2) begin
        // drain the pipeline completely before going on
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (hsl_pending.size() != 0) @(posedge clk);
      end
      r = CH_W'($urandom_range(0, 255));
      g = CH_W'($urandom_range(0, 255));
      b = CH_W'($urandom_range(0, 255));
      v = CH_W'($urandom_range(0, 255));
      w = CH_W'($urandom_range(0, 255));
      case ($urandom_range(0, 8))
        4: begin
          r = v;
          g = v;
          b = v;
        end
        5: begin
          case ($urandom_range(0, 2))
            0: begin r = v; g = v; b = w; end
            1: begin g = v; b = v; r = w; end
            default: begin r = v; b = v; g = w; end
          endcase
        end
        6: begin
          r = {CH_W{1'($urandom_range(0, 1))}};
          g = {CH_W{1'($urandom_range(0, 1))}};
          b = {CH_W{1'($urandom_range(0, 1))}};
        end
        7: begin
          r = v ^ CH_W'($urandom_range(0, 3));
          g = v ^ CH_W'($urandom_range(0, 3));
          b = v ^ CH_W'($urandom_range(0, 3));
        end
        8: begin
          w = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          case ($urandom_range(0, 2))
            0: r = w;
            1: g = w;
            default: b = w;
          endcase
        end
        default: ;
      endcase
      send_pixel(r, g, b, predict_hsl(r, g, b));
    end
    in_chan.valid <= 1'b0;

    while (hsl_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    hsl_t want;
    int   stall;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (out_chan.valid !== 1'b1) @(posedge clk);
      if (hsl_pending.size() == 0) begin
        $error("result with no pending pixel: hue %0d saturation %0d lightness %0d",
               out_chan.hue, out_chan.saturation, out_chan.lightness);
        mismatches++;
      end else begin
        want = hsl_pending.pop_front();
        if (out_chan.hue !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, out_chan.hue);
          mismatches++;
        end
        if (out_chan.saturation !== want.saturation) begin
          $error("saturation: expected %0d, got %0d", want.saturation, out_chan.saturation);
          mismatches++;
        end
        if (out_chan.lightness !== want.lightness) begin
          $error("lightness: expected %0d, got %0d", want.lightness, out_chan.lightness);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
